// ===== hw/rtl/salc_pkg.sv =====
// shared types, constants and helpers for the set-associative lru cache model
// no dependencies

package salc_pkg;

    localparam int SETS = 1024;
    localparam int WAYS = 4;
    localparam int SET_W = 10;
    localparam int WAY_W = 2;
    localparam int TAG_W = 30;
    localparam int RANK_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 248;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY = 2'd2;

    localparam logic [1:0] DIRTY_EVICT_CYCLES = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic valid;
        logic dirty;
        logic [RANK_W-1:0] rank;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] set_entry_t;

    typedef struct packed {
        logic is_write;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [15:0] instrs;
    } req_t;

    typedef struct packed {
        logic hit;
        logic [WAY_W-1:0] way_used;
        logic dirty_eviction;
        logic [16:0] access_cycles;
        logic is_write;
        logic [15:0] instrs;
    } res_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== hw/rtl/set_assoc_lru_writeback_cache_top.sv =====
// top level: set memory with read-modify-write, lookup and statistics
// depends on salc_pkg, salc_lookup, salc_stats
// one item per cycle: s_axis_tready held low only while an output item is not taken or the clearing pass runs
// an accepted access has its set read into rd_reg, then its lookup result registered for output (set read, then update)
// back-to-back accesses to the same set are forwarded from the write-back path
// reset: clearing pass over all 1024 sets, no item accepted meanwhile

module set_assoc_lru_writeback_cache_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [salc_pkg::IN_DATA_W-1:0] s_axis_tdata,  // is_write, byte_address,
                                                           // instruction count, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [salc_pkg::OUT_DATA_W-1:0] m_axis_tdata  // hit, way_used, dirty_eviction,
                                                           // access_cycles,
                                                           // total_hits .. total_writes, pad
);

    logic [2:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [9:0] miss_penalty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 3'd2;
            index_bits_reg <= 4'd8;
            miss_penalty_reg <= 10'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                salc_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data[2:0];
                salc_pkg::REG_INDEX_BITS: index_bits_reg <= cfg_data[3:0];
                salc_pkg::REG_MISS_PENALTY: miss_penalty_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass
    logic clr_busy_reg;
    logic [salc_pkg::SET_W-1:0] clr_addr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == salc_pkg::SET_W'(salc_pkg::SETS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // address split
    logic [29:0] word;
    logic [4:0] sh_tag;
    logic [31:0] set_full;
    salc_pkg::req_t req_in;
    assign word = s_axis_tdata[32:3];
    assign sh_tag = 5'(offset_bits_reg) + 5'(index_bits_reg);
    always_comb
    begin
        set_full = ({2'b0, word} >> offset_bits_reg) & ((32'd1 << index_bits_reg) - 32'd1);
        req_in.is_write = s_axis_tdata[0];
        req_in.set_idx = set_full[salc_pkg::SET_W-1:0];
        req_in.tag = 30'({2'b0, word} >> sh_tag);
        req_in.instrs = s_axis_tdata[48:33];
    end

    // stage 1: request in flight, memory read under way
    logic s1_valid_reg;
    salc_pkg::req_t s1_req_reg;
    logic out_valid_reg;
    salc_pkg::res_t out_res_reg;
    logic stall;
    assign stall = out_valid_reg && !m_axis_tready;
    assign s_axis_tready = !clr_busy_reg && !stall;
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    salc_pkg::set_entry_t mem [salc_pkg::SETS];
    salc_pkg::set_entry_t rd_reg;
    salc_pkg::set_entry_t set_new;
    salc_pkg::res_t res;

    // last write for forwarding
    logic fwd_valid_reg;
    logic [salc_pkg::SET_W-1:0] fwd_addr_reg;
    salc_pkg::set_entry_t fwd_data_reg;

    logic do_upd;
    assign do_upd = s1_valid_reg && !stall;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (do_upd)
            mem[s1_req_reg.set_idx] <= set_new;
        if (acc)
            rd_reg <= mem[req_in.set_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
                s1_valid_reg <= acc;
            if (acc)
                fwd_valid_reg <= do_upd && s1_req_reg.set_idx == req_in.set_idx;
            else if (do_upd && s1_valid_reg)
                fwd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            s1_req_reg <= req_in;
        if (acc)
            fwd_data_reg <= set_new;
        fwd_addr_reg <= s1_req_reg.set_idx;
    end

    salc_pkg::set_entry_t set_cur;
    assign set_cur = (fwd_valid_reg && fwd_addr_reg == s1_req_reg.set_idx) ? fwd_data_reg
                                                                         : rd_reg;

    salc_lookup u_lookup (
        .req(s1_req_reg),
        .set_in(set_cur),
        .miss_penalty(miss_penalty_reg),
        .set_out(set_new),
        .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!stall)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (do_upd)
            out_res_reg <= res;
    end

    logic [31:0] t_hits, t_miss, t_dev, t_cyc, t_ins, t_rd, t_wr;
    salc_stats u_stats (
        .clk(clk),
        .rst_n(rst_n),
        .upd(do_upd),
        .res(res),
        .total_hits(t_hits),
        .total_misses(t_miss),
        .total_dirty_evictions(t_dev),
        .total_cycles(t_cyc),
        .total_instructions(t_ins),
        .total_reads(t_rd),
        .total_writes(t_wr)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {3'b000, t_wr, t_rd, t_ins, t_cyc, t_dev, t_miss, t_hits,
                           out_res_reg.access_cycles, out_res_reg.dirty_eviction,
                           out_res_reg.way_used, out_res_reg.hit};

endmodule

// ===== hw/rtl/salc_lookup.sv =====
// hit detection, victim choice and lru update for one set
// depends on salc_pkg

module salc_lookup (
    input  salc_pkg::req_t     req,
    input  salc_pkg::set_entry_t set_in,
    input  logic [9:0]         miss_penalty,
    output salc_pkg::set_entry_t set_out,
    output salc_pkg::res_t     res
);

    logic hit;
    logic found_inv;
    logic [salc_pkg::WAY_W-1:0] hit_way;
    logic [salc_pkg::WAY_W-1:0] inv_way;
    logic [salc_pkg::WAY_W-1:0] lru_way;
    logic [salc_pkg::WAY_W-1:0] way;
    logic [salc_pkg::RANK_W-1:0] best;
    logic [salc_pkg::RANK_W:0] old_rank;
    logic dev;
    logic [16:0] cyc;

    always_comb
    begin
        hit = 1'b0;
        hit_way = '0;
        found_inv = 1'b0;
        inv_way = '0;
        best = '0;
        lru_way = '0;
        for (int i = salc_pkg::WAYS - 1; i >= 0; i--)
        begin
            if (set_in[i].valid && set_in[i].tag == req.tag)
            begin
                hit = 1'b1;
                hit_way = salc_pkg::WAY_W'(i);
            end
            if (!set_in[i].valid)
            begin
                found_inv = 1'b1;
                inv_way = salc_pkg::WAY_W'(i);
            end
        end
        for (int i = 0; i < salc_pkg::WAYS; i++)
        begin
            if (set_in[i].rank >= best)
            begin
                best = set_in[i].rank;
                lru_way = salc_pkg::WAY_W'(i);
            end
        end
        way = hit ? hit_way : (found_inv ? inv_way : lru_way);
        dev = !hit && !found_inv && set_in[lru_way].dirty;
        cyc = {1'b0, req.instrs};
        if (!hit)
            cyc = cyc + 17'(miss_penalty);
        if (dev)
            cyc = cyc + 17'(salc_pkg::DIRTY_EVICT_CYCLES);
        old_rank = set_in[way].valid ? {1'b0, set_in[way].rank}
                                     : (salc_pkg::RANK_W+1)'(salc_pkg::WAYS);
        set_out = set_in;
        for (int i = 0; i < salc_pkg::WAYS; i++)
        begin
            if (salc_pkg::WAY_W'(i) != way && set_in[i].valid
                && {1'b0, set_in[i].rank} < old_rank)
                set_out[i].rank = set_in[i].rank + 1'b1;
        end
        set_out[way].rank = '0;
        if (hit)
        begin
            if (req.is_write)
                set_out[way].dirty = 1'b1;
        end
        else
        begin
            set_out[way].tag = req.tag;
            set_out[way].valid = 1'b1;
            set_out[way].dirty = req.is_write;
        end
        res.hit = hit;
        res.way_used = way;
        res.dirty_eviction = dev;
        res.access_cycles = cyc;
        res.is_write = req.is_write;
        res.instrs = req.instrs;
    end

endmodule

// ===== hw/rtl/salc_stats.sv =====
// running saturating statistics counters
// depends on salc_pkg

module salc_stats (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            upd,
    input  salc_pkg::res_t  res,
    output logic [31:0]     total_hits,
    output logic [31:0]     total_misses,
    output logic [31:0]     total_dirty_evictions,
    output logic [31:0]     total_cycles,
    output logic [31:0]     total_instructions,
    output logic [31:0]     total_reads,
    output logic [31:0]     total_writes
);

    logic [31:0] hits_reg, misses_reg, devs_reg, cycles_reg, instrs_reg, reads_reg, writes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
            misses_reg <= '0;
            devs_reg <= '0;
            cycles_reg <= '0;
            instrs_reg <= '0;
            reads_reg <= '0;
            writes_reg <= '0;
        end
        else if (upd)
        begin
            hits_reg <= salc_pkg::sat_add(hits_reg, {31'd0, res.hit});
            misses_reg <= salc_pkg::sat_add(misses_reg, {31'd0, !res.hit});
            devs_reg <= salc_pkg::sat_add(devs_reg, {31'd0, res.dirty_eviction});
            cycles_reg <= salc_pkg::sat_add(cycles_reg, {15'd0, res.access_cycles});
            instrs_reg <= salc_pkg::sat_add(instrs_reg, {16'd0, res.instrs});
            reads_reg <= salc_pkg::sat_add(reads_reg, {31'd0, !res.is_write});
            writes_reg <= salc_pkg::sat_add(writes_reg, {31'd0, res.is_write});
        end
    end

    assign total_hits = hits_reg;
    assign total_misses = misses_reg;
    assign total_dirty_evictions = devs_reg;
    assign total_cycles = cycles_reg;
    assign total_instructions = instrs_reg;
    assign total_reads = reads_reg;
    assign total_writes = writes_reg;

endmodule

// ===== dv/salc_checker.sv =====
// checker for the set-associative lru cache: watches the access and result streams,
// predicts each result from its own copy of tags, lru ranks and counters, compares fields
// depends on salc_pkg

module salc_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [9:0]   cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [247:0] m_axis_tdata,
    output int           errors,
    output int           pending,
    output int           hits_seen,
    output int           evictions_seen
);

    typedef struct packed {
        logic        hit;
        logic [1:0]  way_used;
        logic        dirty_eviction;
        logic [16:0] access_cycles;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] dirty_evictions;
        logic [31:0] cycles;
        logic [31:0] instructions;
        logic [31:0] reads;
        logic [31:0] writes;
    } access_result_t;

    logic [2:0]  offset_w;
    logic [3:0]  index_w;
    logic [9:0]  penalty;
    logic [salc_pkg::TAG_W-1:0] tags [salc_pkg::SETS][salc_pkg::WAYS];
    logic        valid [salc_pkg::SETS][salc_pkg::WAYS];
    logic        dirty [salc_pkg::SETS][salc_pkg::WAYS];
    logic [1:0]  rank [salc_pkg::SETS][salc_pkg::WAYS];
    logic [31:0] n_hit, n_miss, n_dev, n_cyc, n_instr, n_rd, n_wr;
    access_result_t expected_q[$];

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic promote(int unsigned set, int unsigned w);
        int unsigned old;
        old = valid[set][w] ? int'(rank[set][w]) : salc_pkg::WAYS;
        for (int i = 0; i < salc_pkg::WAYS; i++)
            if (i != w && valid[set][i] && rank[set][i] < old)
                rank[set][i] = rank[set][i] + 2'd1;
        rank[set][w] = '0;
    endtask

    task automatic predict_access(logic wr, logic [31:0] addr, logic [15:0] instr);
        access_result_t r;
        logic [31:0] word, tag, cyc;
        int unsigned set, way, best;
        logic hit, dev, found;
        word = addr >> 2;
        set = ((word >> offset_w) & ((32'd1 << index_w) - 32'd1)) % salc_pkg::SETS;
        tag = word >> (32'(offset_w) + 32'(index_w));
        hit = 1'b0;
        dev = 1'b0;
        way = 0;
        cyc = 32'(instr);
        for (int i = 0; i < salc_pkg::WAYS; i++)
            if (!hit && valid[set][i] && tags[set][i] == tag[salc_pkg::TAG_W-1:0]
                && tag[31:30] == 2'b00)
            begin
                hit = 1'b1;
                way = i;
            end
        if (hit)
        begin
            promote(set, way);
            if (wr)
                dirty[set][way] = 1'b1;
            n_hit = add_sat(n_hit, 32'd1);
        end
        else
        begin
            found = 1'b0;
            for (int i = 0; i < salc_pkg::WAYS; i++)
                if (!found && !valid[set][i])
                begin
                    way = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                best = 0;
                for (int i = 0; i < salc_pkg::WAYS; i++)
                    if (rank[set][i] >= best)
                    begin
                        best = rank[set][i];
                        way = i;
                    end
                dev = dirty[set][way];
            end
            cyc = cyc + 32'(penalty);
            if (dev)
            begin
                cyc = cyc + 32'(salc_pkg::DIRTY_EVICT_CYCLES);
                n_dev = add_sat(n_dev, 32'd1);
            end
            promote(set, way);
            tags[set][way] = tag[salc_pkg::TAG_W-1:0];
            valid[set][way] = 1'b1;
            dirty[set][way] = wr;
            n_miss = add_sat(n_miss, 32'd1);
        end
        if (wr)
            n_wr = add_sat(n_wr, 32'd1);
        else
            n_rd = add_sat(n_rd, 32'd1);
        n_instr = add_sat(n_instr, 32'(instr));
        n_cyc = add_sat(n_cyc, cyc);
        r = '{hit, way[1:0], dev, cyc[16:0], n_hit, n_miss, n_dev, n_cyc, n_instr, n_rd, n_wr};
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t e;
        logic [244:0] d;
        if (!rst_n)
        begin
            offset_w = 3'd2;
            index_w = 4'd8;
            penalty = 10'd100;
            for (int s = 0; s < salc_pkg::SETS; s++)
                for (int w = 0; w < salc_pkg::WAYS; w++)
                begin
                    valid[s][w] = 1'b0;
                    dirty[s][w] = 1'b0;
                    rank[s][w] = '0;
                    tags[s][w] = '0;
                end
            {n_hit, n_miss, n_dev, n_cyc, n_instr, n_rd, n_wr} = '0;
            expected_q.delete();
            errors = 0;
            pending = 0;
            hits_seen = 0;
            evictions_seen = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    salc_pkg::REG_OFFSET_BITS:  offset_w = cfg_data[2:0];
                    salc_pkg::REG_INDEX_BITS:   index_w = cfg_data[3:0];
                    salc_pkg::REG_MISS_PENALTY: penalty = cfg_data;
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
                predict_access(s_axis_tdata[0], s_axis_tdata[32:1], s_axis_tdata[48:33]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no access waiting");
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    d = m_axis_tdata[244:0];
                    compare("hit", 32'(e.hit), 32'(d[0]));
                    compare("way_used", 32'(e.way_used), 32'(d[2:1]));
                    compare("dirty_eviction", 32'(e.dirty_eviction), 32'(d[3]));
                    compare("access_cycles", 32'(e.access_cycles), 32'(d[20:4]));
                    compare("total_hits", e.hits, d[52:21]);
                    compare("total_misses", e.misses, d[84:53]);
                    compare("total_dirty_evictions", e.dirty_evictions, d[116:85]);
                    compare("total_cycles", e.cycles, d[148:117]);
                    compare("total_instructions", e.instructions, d[180:149]);
                    compare("total_reads", e.reads, d[212:181]);
                    compare("total_writes", e.writes, d[244:213]);
                    hits_seen += int'(e.hit);
                    evictions_seen += int'(e.dirty_eviction);
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== dv/tb_set_assoc_lru_writeback_cache_top.sv =====
// testbench top for set_assoc_lru_writeback_cache_top: clock, reset, register phases,
// directed and random accesses with random stalls on both streams, final verdict
// depends on salc_pkg, salc_checker and the block

module tb_set_assoc_lru_writeback_cache_top;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [9:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [247:0] m_axis_tdata;
    int           errors, pending, hits_seen, evictions_seen;
    int           items_sent;
    logic         quiet;
    logic [2:0]   cur_offset;
    logic [3:0]   cur_index;
    logic [31:0]  addr_pool [16];

    set_assoc_lru_writeback_cache_top dut (.*);

    salc_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    stall = $urandom_range(1, 3);
            end
        end
    end

    task automatic send(logic wr, logic [31:0] addr, logic [15:0] instr);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, instr, addr, wr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic set_regs(logic [2:0] ob, logic [3:0] ib, logic [9:0] pen);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = salc_pkg::REG_OFFSET_BITS;
        cfg_data = 10'(ob);
        @(negedge clk);
        cfg_index = salc_pkg::REG_INDEX_BITS;
        cfg_data = 10'(ib);
        @(negedge clk);
        cfg_index = salc_pkg::REG_MISS_PENALTY;
        cfg_data = pen;
        @(negedge clk);
        cfg_index = REG_UNUSED;
        cfg_data = 10'($urandom);
        @(negedge clk);
        cfg_we = 1'b0;
        cur_offset = ob;
        cur_index = ib;
        for (int i = 0; i < 16; i++)
            addr_pool[i] = ($urandom_range(0, 5) << (32'(ob) + 32'(ib) + 2))
                         | ($urandom_range(0, 2) << (32'(ob) + 2)) | $urandom_range(0, 3);
    endtask

    task automatic random_phase(int n);
        logic [31:0] a;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) < 8)
                a = addr_pool[$urandom_range(0, 15)] ^ ($urandom & ((32'd4 << cur_offset) - 1));
            else
                a = $urandom;
            send(1'($urandom_range(0, 1)), a,
                 $urandom_range(0, 9) == 0 ? 16'hFFFF : 16'($urandom));
        end
    endtask

    initial
    begin
        logic [31:0] stride;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        quiet = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill one set past its ways, dirty victims, extremes
        set_regs(3'd2, 4'd8, 10'd100);
        stride = 32'd1 << (2 + 2 + 8);
        send(1'b0, 32'h0, 16'd0);
        send(1'b1, 32'h0, 16'hFFFF);
        send(1'b1, stride, 16'd1);
        send(1'b0, 2 * stride, 16'd2);
        send(1'b1, 3 * stride, 16'd3);
        send(1'b0, 4 * stride, 16'd4);
        send(1'b0, 5 * stride, 16'd5);
        send(1'b0, 32'h0, 16'd6);
        send(1'b1, 3 * stride, 16'd7);
        send(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        send(1'b1, 32'hFFFF_FFFC, 16'd0);
        send(1'b0, 6 * stride, 16'd8);
        send(1'b0, 7 * stride, 16'd9);
        send(1'b0, 8 * stride, 16'd10);
        send(1'b0, 9 * stride, 16'd11);
        set_regs(3'd0, 4'd0, 10'd0);
        send(1'b1, 32'h4, 16'd1);
        send(1'b1, 32'h8, 16'd1);
        send(1'b0, 32'h4, 16'd1);
        random_phase(80);

        set_regs(3'd6, 4'd10, 10'd1023);
        random_phase(180);
        set_regs(3'd7, 4'd15, 10'd1023);
        random_phase(150);
        set_regs(3'd1, 4'd3, 10'd5);
        random_phase(200);
        set_regs(3'd2, 4'd2, 10'd37);
        random_phase(180);
        set_regs(3'd4, 4'd11, 10'd512);
        quiet = 1'b1;
        random_phase(190);
        s_axis_tvalid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("%0d accesses over 7 register settings, %0d hits, %0d dirty evictions",
                 items_sent, hits_seen, evictions_seen);
        if (errors == 0 && pending == 0)
            $display("set_assoc_lru_writeback_cache_top verification clean");
        else
            $display("set_assoc_lru_writeback_cache_top verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("set_assoc_lru_writeback_cache_top verification failed");
        $finish;
    end

endmodule
